/* rtl/srt_pkg.sv */
package srt_pkg;

  localparam int Entries = 64;
  localparam int SlotW = 6;
  localparam int CountW = 7;
  localparam int ValidBit = 0;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_SHIFT  = 3'd4;
  localparam logic [2:0] CMD_SORT   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  typedef struct packed {
    logic [7:0]         flags;
    logic [7:0]         kind;
    logic [7:0]         param_a;
    logic [7:0]         param_b;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } rec_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         slot;
    logic [7:0]         in_flags;
    logic [7:0]         in_kind;
    logic [7:0]         in_param_a;
    logic [7:0]         in_param_b;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [7:0]         out_flags;
    logic [7:0]         out_kind;
    logic [7:0]         out_param_a;
    logic [7:0]         out_param_b;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [6:0]         valid_count;
  } rsp_t;

  // One memory access issued by the sequencer.
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    rec_t       wdata;
    logic [5:0] raddr;
  } mem_cmd_t;

endpackage

/* rtl/srt_ram.sv */
module srt_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/srt_seq.sv */
module srt_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  srt_pkg::req_t  req,
  output logic           busy,
  output logic           done,
  output srt_pkg::rsp_t  rsp,
  output srt_pkg::mem_cmd_t mc,
  output logic           pass_end,
  output logic [5:0]     tail_addr,
  output srt_pkg::rec_t  tail_data,
  input  srt_pkg::rec_t  rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_SETGET, S_DEL, S_SHIFT, S_SORT_LD, S_SORT,
    S_CLEAR, S_WIPE, S_DONE
  } state_t;

  state_t state;
  srt_pkg::req_t r;
  logic [6:0] idx;       // sweep index, one wider to hold the depth
  logic [6:0] top;       // sort pass limit
  logic [6:0] vcount;    // live count of valid slots
  logic       rd_ok;     // read data of idx-1 is present
  srt_pkg::rec_t hold;   // carried record for delete and sort
  logic       ok;
  srt_pkg::rec_t got;
  logic       tail_pend; // carried record of the finished pass still to be written

  srt_pkg::rec_t new_rec;
  logic rvalid;
  logic [5:0] last_slot;

  assign last_slot = 6'(srt_pkg::Entries - 1);
  assign rvalid = rdata.flags[srt_pkg::ValidBit];

  always_comb begin
    new_rec = '{flags: r.in_flags, kind: r.in_kind, param_a: r.in_param_a,
                param_b: r.in_param_b, x: r.in_x, y: r.in_y};
    new_rec.flags[srt_pkg::ValidBit] = 1'b1;
  end

  assign busy = (state != S_IDLE);

  // The carried record lands in the last slot of the pass while the next
  // pass starts its read of slot 0.
  assign pass_end = (state == S_SORT_LD) && tail_pend;
  assign tail_addr = top[5:0];
  assign tail_data = hold;

  always_comb begin
    mc = '0;
    mc.raddr = idx[5:0];
    unique case (state)
      S_ADD: begin
        if (rd_ok && !rvalid) begin
          mc.we = 1'b1; mc.waddr = 6'(idx - 7'd1); mc.wdata = new_rec;
        end
      end
      S_SETGET: begin
        mc.raddr = r.slot;
        if (rd_ok && rvalid && r.cmd == srt_pkg::CMD_SET) begin
          mc.we = 1'b1; mc.waddr = r.slot; mc.wdata = new_rec;
        end
      end
      S_DEL: begin
        // The read of the deleted slot itself moves nothing.
        if (rd_ok && idx != {1'b0, r.slot} + 7'd1) begin
          mc.we = 1'b1; mc.waddr = 6'(idx - 7'd2); mc.wdata = rdata;
          if (idx == 7'(srt_pkg::Entries) + 7'd1) begin
            mc.waddr = last_slot;
            mc.wdata = hold;
            mc.wdata.flags = '0;
          end
        end
      end
      S_SHIFT: begin
        if (rd_ok && rvalid) begin
          mc.we = 1'b1; mc.waddr = 6'(idx - 7'd1); mc.wdata = rdata;
          mc.wdata.x = rdata.x + r.in_x;
          mc.wdata.y = rdata.y + r.in_y;
        end
      end
      S_SORT: begin
        // hold is slot idx-2 so far; rdata is slot idx-1.
        if (rd_ok) begin
          mc.we = 1'b1; mc.waddr = 6'(idx - 7'd2);
          mc.wdata = ($signed(hold.y) < $signed(rdata.y)) ? rdata : hold;
        end
      end
      S_CLEAR, S_WIPE: begin
        mc.we = 1'b1; mc.waddr = idx[5:0]; mc.wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      idx <= '0;
      vcount <= '0;
      rd_ok <= 1'b0;
      done <= 1'b0;
      top <= '0;
      tail_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          ok <= 1'b0;
          got <= '0;
          rd_ok <= 1'b0;
          idx <= '0;
          if (start) begin
            r <= req;
            priority case (req.cmd)
              srt_pkg::CMD_ADD:    state <= S_ADD;
              srt_pkg::CMD_SET,
              srt_pkg::CMD_GET:    state <= S_SETGET;
              srt_pkg::CMD_DELETE: begin
                state <= S_DEL; idx <= {1'b0, req.slot};
              end
              srt_pkg::CMD_SHIFT:  state <= S_SHIFT;
              srt_pkg::CMD_SORT: begin
                top <= vcount; state <= S_SORT_LD;
              end
              srt_pkg::CMD_CLEAR:  state <= S_CLEAR;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_ADD: begin
          idx <= idx + 7'd1;
          rd_ok <= 1'b1;
          if (rd_ok && !rvalid) begin
            ok <= 1'b1; vcount <= vcount + 7'd1; state <= S_DONE;
          end else if (idx == 7'(srt_pkg::Entries)) begin
            state <= S_DONE;
          end
        end
        S_SETGET: begin
          rd_ok <= 1'b1;
          if (rd_ok) begin
            ok <= rvalid;
            if (rvalid && r.cmd == srt_pkg::CMD_GET) got <= rdata;
            state <= S_DONE;
          end
        end
        S_DEL: begin
          // First read fetches the deleted slot for its valid bit.
          idx <= idx + 7'd1;
          rd_ok <= 1'b1;
          if (rd_ok && idx == {1'b0, r.slot} + 7'd1) begin
            if (rdata.flags[srt_pkg::ValidBit]) vcount <= vcount - 7'd1;
          end
          if (idx == 7'(srt_pkg::Entries)) hold <= rdata;
          if (rd_ok && idx == 7'(srt_pkg::Entries) + 7'd1) begin
            ok <= 1'b1; state <= S_DONE;
          end
        end
        S_SHIFT: begin
          idx <= idx + 7'd1;
          rd_ok <= 1'b1;
          if (idx == 7'(srt_pkg::Entries)) begin
            ok <= 1'b1; state <= S_DONE;
          end
        end
        S_SORT_LD: begin
          // Start one pass by reading slot 0, or finish the sort when fewer than two slots are left.
          ok <= 1'b1;
          tail_pend <= 1'b0;
          if (top < 7'd2) begin
            state <= S_DONE;
          end else begin
            idx <= 7'd1; rd_ok <= 1'b0; state <= S_SORT;
          end
        end
        S_SORT: begin
          idx <= idx + 7'd1;
          rd_ok <= 1'b1;
          if (!rd_ok) begin
            hold <= rdata;
          end else begin
            hold <= ($signed(hold.y) < $signed(rdata.y)) ? hold : rdata;
          end
          if (rd_ok && idx == top) begin
            state <= S_SORT_LD; top <= top - 7'd1; idx <= '0;
            rd_ok <= 1'b0; tail_pend <= 1'b1;
          end
        end
        S_CLEAR: begin
          idx <= idx + 7'd1;
          if (idx == 7'(srt_pkg::Entries - 1)) begin
            vcount <= '0; ok <= 1'b1; state <= S_DONE;
          end
        end
        S_WIPE: begin
          idx <= idx + 7'd1;
          if (idx == 7'(srt_pkg::Entries - 1)) state <= S_IDLE;
        end
        S_DONE: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp = '{ok: ok, out_flags: got.flags, out_kind: got.kind,
                 out_param_a: got.param_a, out_param_b: got.param_b,
                 out_x: got.x, out_y: got.y, valid_count: vcount};

endmodule

/* rtl/srt_tail.sv */
module srt_tail (
  input  srt_pkg::mem_cmd_t mc_in,
  input  logic              pass_end,
  input  logic [5:0]        tail_addr,
  input  srt_pkg::rec_t     tail_data,
  output srt_pkg::mem_cmd_t mc_out
);

  // Merges the end-of-pass write of the carried record into the port.
  always_comb begin
    mc_out = mc_in;
    if (pass_end) begin
      mc_out.we = 1'b1;
      mc_out.waddr = tail_addr;
      mc_out.wdata = tail_data;
    end
  end

endmodule

/* rtl/slot_record_table.sv */
// Add, shift, delete, clear and sort sweep the record memory one entry per cycle
// through its one read port and one write port; get and set touch a single slot.
// Throughput: one request at a time; start is taken while busy is low, again from
// the done cycle on. The receiver cannot stall: done lasts one cycle.
// Reset clears control state and the valid count, then holds busy high while the
// record memory is zeroed.
module slot_record_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  srt_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output srt_pkg::rsp_t rsp
);

  srt_pkg::mem_cmd_t mc_seq;
  srt_pkg::mem_cmd_t mc;
  srt_pkg::rec_t     rdata;
  logic              pass_end;
  logic [5:0]        tail_addr;
  srt_pkg::rec_t     tail_data;

  // The sequencer owns all memory traffic; every walk is read, modify and
  // write back in the cycle after the read, so no entry is read before its write lands.
  srt_seq u_seq (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp), .mc(mc_seq),
    .pass_end(pass_end), .tail_addr(tail_addr), .tail_data(tail_data),
    .rdata(rdata)
  );

  // At the end of each sort pass the carried record is written to the last
  // slot of that pass.
  srt_tail u_tail (
    .mc_in(mc_seq), .pass_end(pass_end), .tail_addr(tail_addr),
    .tail_data(tail_data), .mc_out(mc)
  );

  srt_ram #(.Depth(srt_pkg::Entries), .AddrW(srt_pkg::SlotW), .DataW(64)) u_ram (
    .clk(clk), .we(mc.we), .waddr(mc.waddr), .wdata(mc.wdata),
    .raddr(mc.raddr), .rdata(rdata)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for two cycles");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid_count <= 7'(srt_pkg::Entries)) else $error("valid count overflow");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");

endmodule
